>>> src/gmca_pkg.sv
// ----------------------------------------------------------------------------
// gmca_pkg: shared types and constants for the grid map cell accumulator
// Command codes, status codes, map types, register indexes, state types and
// the cell arithmetic helpers used by the front, back and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package gmca_pkg;

  // Q24.8 constants
  localparam logic [31:0] ONE_Q     = 32'd256;
  localparam logic [31:0] GRAY_Q    = 32'd32768;
  localparam logic [31:0] OCC_HIT_Q = 32'd1280;
  localparam logic [7:0]  INVALID_CLASS = 8'd19;

  // divider sizing: |(s*256 - avg)| * 256 fits in 41 bits
  localparam int DIVW = 41;
  localparam int DCW  = 6;

  // command codes
  localparam logic [1:0] FN_ADD  = 2'd0;
  localparam logic [1:0] FN_READ = 2'd1;
  localparam logic [1:0] FN_INIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_BADCLASS = 2'd2;

  // map types
  localparam logic [1:0] MT_VISUAL   = 2'd0;
  localparam logic [1:0] MT_REFL     = 2'd1;
  localparam logic [1:0] MT_SEMANTIC = 2'd2;
  localparam logic [1:0] MT_OCC      = 2'd3;

  typedef enum logic [2:0] {
    RA_MAP_TYPE, RA_ORIGIN_X, RA_ORIGIN_Y, RA_CPM,
    RA_WIDTH, RA_HEIGHT, RA_CLASSES, RA_SPARE
  } reg_idx_t;

  // cell location settings used by the front
  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [15:0] cells_per_meter;
    logic [7:0]  width_cells;
    logic [7:0]  height_cells;
  } loc_cfg_t;

  // map settings used by the back
  typedef struct packed {
    logic [1:0] mtype;
    logic [4:0] num_classes;
  } map_cfg_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_CLS} front_st_t;

  typedef enum logic [3:0] {
    B_CLR, B_IDLE, B_DISP, B_FILL, B_UNK, B_RDA, B_RDO, B_SKIP,
    B_CRD, B_CLAT, B_ARD, B_ACALC, B_ADIV, B_ORD, B_OWR, B_WR
  } back_st_t;

  typedef enum logic {D_IDLE, D_RUN} div_st_t;

  // saturating add of two Q24.8 words
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // value of field k of an unobserved cell
  function automatic logic [31:0] unknown_of(input logic [1:0] mt, input logic [4:0] n,
                                             input logic [6:0] k);
    logic [31:0] v;
    v = '0;
    case (mt)
      MT_VISUAL:   v = (k == 7'd3) ? ONE_Q : GRAY_Q;
      MT_REFL:     v = (k == 7'd1) ? ONE_Q : GRAY_Q;
      MT_SEMANTIC: begin
        if (k < {2'b0, n}) v = ONE_Q;
        else if (k == {2'b0, n}) v = {19'b0, n, 8'h00};
        else v = '0;
      end
      default:     v = (k == 7'd0) ? ONE_Q : 32'd512;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/gmca_div.sv
// ----------------------------------------------------------------------------
// gmca_div: serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gmca_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [gmca_pkg::DIVW-1:0]  dividend,
  input  wire logic [31:0]                divisor,
  output logic                            done,
  output logic [gmca_pkg::DIVW-1:0]       quotient
);
  import gmca_pkg::*;

  div_st_t           st_r, st_nxt;
  logic [DCW-1:0]    cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [31:0]       rem_r, rem_nxt;
  logic [DIVW-1:0]   quo_r, quo_nxt;
  logic [31:0]       dvs_r, dvs_nxt;
  logic [32:0]       trial;
  logic [32:0]       diff;

  // one restoring step
  always_comb begin
    trial    = {rem_r, quo_r[DIVW-1]};
    diff     = trial - {1'b0, dvs_r};
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    case (st_r)
      D_IDLE: begin
        if (start) begin
          rem_nxt = '0;
          quo_nxt = dividend;
          dvs_nxt = divisor;
          cnt_nxt = '0;
          st_nxt  = D_RUN;
        end
      end
      D_RUN: begin
        if (!diff[32]) begin
          rem_nxt = diff[31:0];
          quo_nxt = {quo_r[DIVW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[DIVW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DCW'(DIVW - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = D_IDLE;
        end
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> src/gmca_fifo.sv
// ----------------------------------------------------------------------------
// gmca_fifo: command queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmca_fifo #(
  parameter int DW    = 41,
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [DW-1:0] push_data,
  input  wire logic          pop,
  output logic [DW-1:0]      pop_data,
  output logic               full,
  output logic               empty
);
  localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CTW = $clog2(DEPTH + 1);

  logic [DW-1:0]  q_r [DEPTH];
  logic [PTW-1:0] wp_r, rp_r;
  logic [CTW-1:0] cnt_r;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CTW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_r[rp_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PTW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PTW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CTW'(do_push) - CTW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= push_data;
  end

endmodule

`default_nettype wire

>>> src/gmca_front.sv
// ----------------------------------------------------------------------------
// gmca_front: command intake and cell location
// Latches a command, scales the offsets to cells and queues it with the cell
// number and an in-tile flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gmca_front #(
  parameter int TILE_SIDE = 128,
  parameter int CW        = 14,
  parameter int QW        = 41
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [1:0]         func,
  input  wire logic [31:0]        x_coord,
  input  wire logic [31:0]        y_coord,
  input  wire logic [7:0]         sample_r,
  input  wire logic [7:0]         sample_g,
  input  wire logic [7:0]         sample_b,
  input  wire gmca_pkg::loc_cfg_t loc_cfg,
  input  wire logic               q_full,
  output logic                    q_push,
  output logic [QW-1:0]           q_data,
  output logic                    f_busy
);
  import gmca_pkg::*;

  localparam int PW = $clog2(TILE_SIDE);

  front_st_t          st_r, st_nxt;
  logic [1:0]         func_r;
  logic [31:0]        x_r, y_r;
  logic [7:0]         r_r, g_r, b_r;
  logic signed [49:0] px_prod_r, py_prod_r;
  logic signed [32:0] dx, dy;
  logic [PW:0]        ax, ay;
  logic [CW-1:0]      cell_num;
  logic               in_tile;

  // clamp the tile extent and test one axis; msb is the in-range flag
  function automatic logic [PW:0] axis_cell(input logic signed [49:0] p,
                                            input logic [7:0] lim8);
    logic [15:0] lim;
    logic [33:0] q;
    logic        ok;
    lim = ({8'b0, lim8} > 16'(TILE_SIDE)) ? 16'(TILE_SIDE) : {8'b0, lim8};
    q   = p[49:16];
    if (p[49]) begin
      // small negative offsets truncate to cell zero
      ok = (&p[49:16]) && (|p[15:0]);
      return {ok, {PW{1'b0}}};
    end
    ok = (q < {18'b0, lim});
    return {ok, q[PW-1:0]};
  endfunction

  assign dx = $signed({x_r[31], x_r}) - $signed({loc_cfg.origin_x[31], loc_cfg.origin_x});
  assign dy = $signed({y_r[31], y_r}) - $signed({loc_cfg.origin_y[31], loc_cfg.origin_y});

  always_comb begin
    ax       = axis_cell(px_prod_r, loc_cfg.width_cells);
    ay       = axis_cell(py_prod_r, loc_cfg.height_cells);
    in_tile  = ax[PW] && ay[PW];
    cell_num = CW'(ay[PW-1:0]) * CW'(TILE_SIDE) + CW'(ax[PW-1:0]);
  end

  // intake sequencer
  always_comb begin
    st_nxt = st_r;
    q_push = 1'b0;
    case (st_r)
      F_IDLE: if (accept) st_nxt = F_MUL;
      F_MUL:  st_nxt = F_CLS;
      F_CLS: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  assign q_data = {func_r, in_tile, cell_num, r_r, g_r, b_r};
  assign f_busy = (st_r != F_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= F_IDLE;
    else        st_r <= st_nxt;
  end

  // command capture and offset scaling
  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && accept) begin
      func_r <= func;
      x_r    <= x_coord;
      y_r    <= y_coord;
      r_r    <= sample_r;
      g_r    <= sample_g;
      b_r    <= sample_b;
    end
    if (st_r == F_MUL) begin
      px_prod_r <= 50'(dx * $signed({1'b0, loc_cfg.cells_per_meter}));
      py_prod_r <= 50'(dy * $signed({1'b0, loc_cfg.cells_per_meter}));
    end
  end

endmodule

`default_nettype wire

>>> src/gmca_back.sv
// ----------------------------------------------------------------------------
// gmca_back: cell store and update sequencer
// Holds the cell words and observed bits, runs the per-type update, the
// field read-out, the tile fill and the observed clear after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gmca_back #(
  parameter int TILE_SIDE  = 128,
  parameter int MAX_FIELDS = 22,
  parameter int CW         = 14,
  parameter int QW         = 41
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gmca_pkg::map_cfg_t map_cfg,
  input  wire logic               q_empty,
  input  wire logic [QW-1:0]      q_data,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [4:0]              out_field_index,
  output logic [31:0]             out_field_value,
  output logic                    out_observed,
  output logic                    out_last
);
  import gmca_pkg::*;

  localparam int KW    = $clog2(MAX_FIELDS);
  localparam int FW    = $clog2(MAX_FIELDS + 1);
  localparam int AW    = CW + KW;
  localparam int NCELL = TILE_SIDE * TILE_SIDE;

  // storage
  logic [31:0] cell_mem [2**AW];
  logic        obs_mem  [2**CW];

  back_st_t      st_r, st_nxt;
  logic [QW-1:0] ent_r, ent_nxt;
  logic [FW-1:0] k_r, k_nxt;
  logic [CW-1:0] sw_r, sw_nxt;
  logic [1:0]    j_r, j_nxt;
  logic          op_r, op_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic [31:0]   avg_r, avg_nxt;
  logic          neg_r, neg_nxt;
  logic [31:0]   rd_data_r;
  logic          obs_rd_r;

  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [4:0]    oidx_r, oidx_nxt;
  logic [31:0]   oval_r, oval_nxt;
  logic          oobs_r, oobs_nxt;
  logic          olast_r, olast_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;
  logic          obs_we, obs_wd;
  logic [CW-1:0] obs_wa;

  // entry fields
  logic [1:0]    e_func;
  logic          e_in;
  logic [CW-1:0] e_cell;
  logic [7:0]    e_r, e_g, e_b;

  logic [4:0]    cls;
  logic [FW-1:0] nf;
  logic [31:0]   unk;
  logic          sem_bad;
  logic          k_last;

  // update plan
  logic          op_en0, op_en1, wr_en;
  logic [KW-1:0] op_idx0, op_idx1, wr_idx, cnt_idx;
  logic [31:0]   op_add0, op_add1;
  logic          cur_en;
  logic [KW-1:0] cur_idx;
  logic [31:0]   cur_add;
  logic [7:0]    smp;
  logic [31:0]   smp_q;
  logic signed [33:0] diff;
  logic [32:0]   mag;
  logic          div_start, div_done;
  logic [DIVW-1:0] div_q;
  logic [31:0]   new_avg;
  logic          avg_more;

  assign e_func = ent_r[QW-1 -: 2];
  assign e_in   = ent_r[QW-3];
  assign e_cell = ent_r[QW-4 -: CW];
  assign e_r    = ent_r[23:16];
  assign e_g    = ent_r[15:8];
  assign e_b    = ent_r[7:0];

  // field counts for the current map type
  always_comb begin
    cls = ({2'b0, map_cfg.num_classes} > 7'(MAX_FIELDS - 2)) ? 5'(MAX_FIELDS - 2)
                                                             : map_cfg.num_classes;
    case (map_cfg.mtype)
      MT_VISUAL:   nf = FW'(4);
      MT_SEMANTIC: nf = FW'(cls) + FW'(2);
      default:     nf = FW'(2);
    endcase
    unk     = unknown_of(map_cfg.mtype, cls, 7'(k_r));
    sem_bad = (e_r == INVALID_CLASS) || (e_r >= {3'b0, cls});
    k_last  = (k_r + 1'b1 == nf);
  end

  // read-modify-write plan per map type
  always_comb begin
    op_en0  = 1'b0;
    op_idx0 = '0;
    op_add0 = ONE_Q;
    op_en1  = 1'b1;
    op_idx1 = KW'(1);
    op_add1 = ONE_Q;
    wr_en   = 1'b0;
    wr_idx  = '0;
    cnt_idx = KW'(1);
    case (map_cfg.mtype)
      MT_VISUAL: begin
        op_idx1 = KW'(3);
        cnt_idx = KW'(3);
      end
      MT_REFL: ;
      MT_SEMANTIC: begin
        op_en0  = 1'b1;
        op_idx0 = e_r[KW-1:0];
        op_idx1 = KW'(cls);
        wr_en   = 1'b1;
        wr_idx  = KW'(cls) + KW'(1);
      end
      default: begin
        op_en0  = (e_r != 8'd0);
        op_add0 = OCC_HIT_Q;
        op_add1 = (e_r != 8'd0) ? OCC_HIT_Q : ONE_Q;
      end
    endcase
    cur_en  = op_r ? op_en1 : op_en0;
    cur_idx = op_r ? op_idx1 : op_idx0;
    cur_add = op_r ? op_add1 : op_add0;
  end

  // running average arithmetic
  always_comb begin
    if (map_cfg.mtype == MT_VISUAL) begin
      case (j_r)
        2'd0:    smp = e_b;
        2'd1:    smp = e_g;
        default: smp = e_r;
      endcase
    end else begin
      smp = e_r;
    end
    smp_q    = {16'b0, smp, 8'h00};
    diff     = $signed({2'b0, smp_q}) - $signed({2'b0, rd_data_r});
    mag      = diff[33] ? 33'(-diff) : diff[32:0];
    new_avg  = neg_r ? (avg_r - div_q[31:0]) : (avg_r + div_q[31:0]);
    avg_more = (map_cfg.mtype == MT_VISUAL) && (j_r != 2'd2);
  end

  gmca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag, 8'h00}),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    ent_nxt   = ent_r;
    k_nxt     = k_r;
    sw_nxt    = sw_r;
    j_nxt     = j_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    avg_nxt   = avg_r;
    neg_nxt   = neg_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    oidx_nxt  = oidx_r;
    oval_nxt  = oval_r;
    oobs_nxt  = oobs_r;
    olast_nxt = olast_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = {e_cell, k_r[KW-1:0]};
    mem_wd    = '0;
    mem_ra    = {e_cell, k_r[KW-1:0]};
    obs_we    = 1'b0;
    obs_wa    = e_cell;
    obs_wd    = 1'b0;
    div_start = 1'b0;
    case (st_r)
      // observed clear after reset
      B_CLR: begin
        obs_we = 1'b1;
        obs_wa = sw_r;
        if (sw_r == CW'(NCELL - 1)) begin
          sw_nxt = '0;
          st_nxt = B_IDLE;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_data;
          st_nxt  = B_DISP;
        end
      end
      B_DISP: begin
        k_nxt  = '0;
        j_nxt  = '0;
        op_nxt = 1'b0;
        sw_nxt = '0;
        case (e_func)
          FN_ADD: begin
            if (!e_in) begin
              ov_nxt = 1'b1; ost_nxt = ST_OUTSIDE; oidx_nxt = '0;
              oval_nxt = '0; oobs_nxt = 1'b0; olast_nxt = 1'b1;
              st_nxt = B_IDLE;
            end else begin
              case (map_cfg.mtype)
                MT_VISUAL, MT_REFL: st_nxt = B_CRD;
                MT_SEMANTIC:        st_nxt = sem_bad ? B_SKIP : B_ORD;
                default:            st_nxt = B_ORD;
              endcase
            end
          end
          FN_READ: st_nxt = e_in ? B_RDA : B_UNK;
          FN_INIT: st_nxt = B_FILL;
          default: begin
            ov_nxt = 1'b1; ost_nxt = ST_DONE; oidx_nxt = '0;
            oval_nxt = '0; oobs_nxt = 1'b0; olast_nxt = 1'b1;
            st_nxt = B_IDLE;
          end
        endcase
      end
      // tile fill, one word a cycle
      B_FILL: begin
        mem_we = 1'b1;
        mem_wa = {sw_r, k_r[KW-1:0]};
        mem_wd = (k_r < nf) ? unk : '0;
        if (k_r == '0) begin
          obs_we = 1'b1;
          obs_wa = sw_r;
        end
        if (k_r == FW'(MAX_FIELDS - 1)) begin
          k_nxt = '0;
          if (sw_r == CW'(NCELL - 1)) begin
            sw_nxt = '0;
            ov_nxt = 1'b1; ost_nxt = ST_DONE; oidx_nxt = '0;
            oval_nxt = '0; oobs_nxt = 1'b0; olast_nxt = 1'b1;
            st_nxt = B_IDLE;
          end else begin
            sw_nxt = sw_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      B_UNK: begin
        ov_nxt = 1'b1; ost_nxt = ST_OUTSIDE; oidx_nxt = 5'(k_r);
        oval_nxt = unk; oobs_nxt = 1'b0; olast_nxt = k_last;
        k_nxt  = k_r + 1'b1;
        if (k_last) st_nxt = B_IDLE;
      end
      B_RDA: st_nxt = B_RDO;
      B_RDO: begin
        ov_nxt = 1'b1; ost_nxt = ST_DONE; oidx_nxt = 5'(k_r);
        oval_nxt = rd_data_r; oobs_nxt = obs_rd_r; olast_nxt = k_last;
        k_nxt  = k_r + 1'b1;
        st_nxt = k_last ? B_IDLE : B_RDA;
      end
      B_SKIP: begin
        ov_nxt = 1'b1; ost_nxt = ST_BADCLASS; oidx_nxt = '0;
        oval_nxt = '0; oobs_nxt = obs_rd_r; olast_nxt = 1'b1;
        st_nxt = B_IDLE;
      end
      // hit count of the cell
      B_CRD: begin
        mem_ra = {e_cell, cnt_idx};
        st_nxt = B_CLAT;
      end
      B_CLAT: begin
        cnt_nxt = rd_data_r;
        st_nxt  = B_ARD;
      end
      B_ARD: begin
        mem_ra = {e_cell, KW'(j_r)};
        st_nxt = B_ACALC;
      end
      B_ACALC: begin
        avg_nxt = rd_data_r;
        neg_nxt = diff[33];
        if (cnt_r <= ONE_Q) begin
          // first sample replaces the average
          mem_we = 1'b1;
          mem_wa = {e_cell, KW'(j_r)};
          mem_wd = smp_q;
          if (avg_more) begin
            j_nxt  = j_r + 1'b1;
            st_nxt = B_ARD;
          end else begin
            st_nxt = B_ORD;
          end
        end else begin
          div_start = 1'b1;
          st_nxt    = B_ADIV;
        end
      end
      B_ADIV: begin
        if (div_done) begin
          mem_we = 1'b1;
          mem_wa = {e_cell, KW'(j_r)};
          mem_wd = new_avg;
          if (avg_more) begin
            j_nxt  = j_r + 1'b1;
            st_nxt = B_ARD;
          end else begin
            st_nxt = B_ORD;
          end
        end
      end
      // saturating field increments
      B_ORD: begin
        mem_ra = {e_cell, cur_idx};
        if (cur_en) st_nxt = B_OWR;
        else if (op_r) st_nxt = B_WR;
        else op_nxt = 1'b1;
      end
      B_OWR: begin
        mem_we = 1'b1;
        mem_wa = {e_cell, cur_idx};
        mem_wd = sat_add(rd_data_r, cur_add);
        if (op_r) begin
          st_nxt = B_WR;
        end else begin
          op_nxt = 1'b1;
          st_nxt = B_ORD;
        end
      end
      B_WR: begin
        mem_we = wr_en;
        mem_wa = {e_cell, wr_idx};
        mem_wd = ONE_Q;
        obs_we = 1'b1;
        obs_wd = 1'b1;
        ov_nxt = 1'b1; ost_nxt = ST_DONE; oidx_nxt = '0;
        oval_nxt = '0; oobs_nxt = 1'b1; olast_nxt = 1'b1;
        st_nxt = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_CLR;
      sw_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sw_r <= sw_nxt;
      ov_r <= ov_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    ent_r   <= ent_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    avg_r   <= avg_nxt;
    neg_r   <= neg_nxt;
    ost_r   <= ost_nxt;
    oidx_r  <= oidx_nxt;
    oval_r  <= oval_nxt;
    oobs_r  <= oobs_nxt;
    olast_r <= olast_nxt;
  end

  // cell word memory
  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_wa] <= mem_wd;
    rd_data_r <= cell_mem[mem_ra];
  end

  // observed bit memory
  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[obs_wa] <= obs_wd;
    obs_rd_r <= obs_mem[e_cell];
  end

  assign clearing        = (st_r == B_CLR);
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_field_index = oidx_r;
  assign out_field_value = oval_r;
  assign out_observed    = oobs_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

>>> src/grid_map_cell_accumulator.sv
// ----------------------------------------------------------------------------
// grid_map_cell_accumulator: one map tile with per-cell accumulation
// Add a point, read a cell or fill the tile; registers via an APB port.
// ----------------------------------------------------------------------------
// Flow: the front latches a command, scales its offsets to cells and queues it;
//   the back updates or reads the cell and strobes the result; an average field
//   divided by a count above one goes through the serial divider.
// Read: one result per field, unknown values outside the tile. Fill: writes every
//   word of the tile. A new command is taken once the front has queued the last.
// Reset: busy stays high while the observed bits are cleared.
`default_nettype none

module grid_map_cell_accumulator #(
  parameter int TILE_SIDE  = 128,
  parameter int MAX_FIELDS = 22
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_x_coord,
  input  wire logic [31:0] in_y_coord,
  input  wire logic [7:0]  in_sample_r,
  input  wire logic [7:0]  in_sample_g,
  input  wire logic [7:0]  in_sample_b,
  // result channel
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [4:0]       out_field_index,
  output logic [31:0]      out_field_value,
  output logic             out_observed,
  output logic             out_last,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gmca_pkg::*;

  localparam int CW = $clog2(TILE_SIDE * TILE_SIDE);
  localparam int QW = CW + 27;

  logic [1:0]  mtype_r;
  logic [31:0] origin_x_r, origin_y_r;
  logic [15:0] cpm_r;
  logic [7:0]  width_r, height_r;
  logic [4:0]  classes_r;
  logic        wr_en;
  reg_idx_t    ridx;

  loc_cfg_t    loc_cfg;
  map_cfg_t    map_cfg;
  logic        f_busy, clearing, accept;
  logic        q_push, q_pop, q_full, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // register writes
  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mtype_r    <= MT_VISUAL;
      origin_x_r <= '0;
      origin_y_r <= '0;
      cpm_r      <= 16'd1280;
      width_r    <= 8'd128;
      height_r   <= 8'd128;
      classes_r  <= 5'd20;
    end else if (wr_en) begin
      case (ridx)
        RA_MAP_TYPE: mtype_r    <= pwdata[1:0];
        RA_ORIGIN_X: origin_x_r <= pwdata;
        RA_ORIGIN_Y: origin_y_r <= pwdata;
        RA_CPM:      cpm_r      <= pwdata[15:0];
        RA_WIDTH:    width_r    <= pwdata[7:0];
        RA_HEIGHT:   height_r   <= pwdata[7:0];
        RA_CLASSES:  classes_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      RA_MAP_TYPE: prdata = {30'b0, mtype_r};
      RA_ORIGIN_X: prdata = origin_x_r;
      RA_ORIGIN_Y: prdata = origin_y_r;
      RA_CPM:      prdata = {16'b0, cpm_r};
      RA_WIDTH:    prdata = {24'b0, width_r};
      RA_HEIGHT:   prdata = {24'b0, height_r};
      RA_CLASSES:  prdata = {27'b0, classes_r};
      default:     prdata = '0;
    endcase
  end

  assign loc_cfg = '{origin_x: origin_x_r, origin_y: origin_y_r,
                     cells_per_meter: cpm_r, width_cells: width_r,
                     height_cells: height_r};
  assign map_cfg = '{mtype: mtype_r, num_classes: classes_r};

  assign busy   = f_busy || clearing;
  assign accept = start && !busy;

  gmca_front #(.TILE_SIDE(TILE_SIDE), .CW(CW), .QW(QW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .func     (in_func),
    .x_coord  (in_x_coord),
    .y_coord  (in_y_coord),
    .sample_r (in_sample_r),
    .sample_g (in_sample_g),
    .sample_b (in_sample_b),
    .loc_cfg  (loc_cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .f_busy   (f_busy)
  );

  gmca_fifo #(.DW(QW), .DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  gmca_back #(.TILE_SIDE(TILE_SIDE), .MAX_FIELDS(MAX_FIELDS), .CW(CW), .QW(QW)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .map_cfg         (map_cfg),
    .q_empty         (q_empty),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_observed    (out_observed),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
